[rtl/sfp_pkg.sv]
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types, constants and the byte-wise CRC-32 update for the sample
// frame packer.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 32;

    localparam int CFG_W     = 6;
    localparam int CFG_ADR_W = 1;
    localparam int GEOM_W    = 2 * CFG_W;
    localparam int BUF_BYTES = 10;
    localparam int BUF_W     = 8 * BUF_BYTES;
    localparam int CNT_W     = 4;

    localparam logic [CFG_ADR_W-1:0] REG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_ADR_W-1:0] REG_COLUMN_COUNT = 1'd1;

    localparam logic [CFG_W-1:0] ROW_COUNT_RST    = 6'd32;
    localparam logic [CFG_W-1:0] COLUMN_COUNT_RST = 6'd32;

    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [7:0]  HDR_BYTE0 = 8'hFF;
    localparam logic [7:0]  HDR_BYTE1 = 8'h66;

    // one frame record: bytes in transfer order, lowest byte first
    typedef struct packed {
        logic [BUF_W-1:0] bytes;
        logic [CNT_W-1:0] count;
        logic             fin;
        logic             err;
    } sfp_rec_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/sfp_framer.sv]
// ----------------------------------------------------------------------------
// sfp_framer
// Sample intake: holds the geometry registers, frame position and running
// CRC, and turns each sample transfer into one frame record.
// ----------------------------------------------------------------------------
module sfp_framer #(
    parameter int MAX_ROWS = sfp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = sfp_pkg::DEF_MAX_COLS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sfp_pkg::CFG_ADR_W-1:0] cfg_addr,
    input  logic [sfp_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,
    output sfp_pkg::sfp_rec_t             rec,
    output logic                          rec_valid,
    input  logic                          rec_take
);
    import sfp_pkg::*;

    localparam int IDX_W = $clog2(MAX_ROWS * MAX_COLS + 1);
    localparam int CMP_W = (IDX_W > GEOM_W) ? IDX_W : GEOM_W;

    logic [CFG_W-1:0]  row_count_reg;
    logic [CFG_W-1:0]  column_count_reg;
    logic [31:0]       crc_reg, crc_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              pend_valid_reg;
    sfp_rec_t          pend_reg, rec_new;

    logic [15:0]       smp, cnt;
    logic              accept, geom_ok, first, fin;
    logic [GEOM_W-1:0] total;
    logic [IDX_W-1:0]  idx_inc;
    logic [31:0]       crc_hdr, crc_dat, crc_out;
    logic [15:0]       dat_bytes;
    logic [31:0]       hdr_bytes;

    assign smp = s_tdata[15:0];
    assign cnt = s_tdata[31:16];

    assign s_tready  = !pend_valid_reg || rec_take;
    assign accept    = s_tvalid && s_tready;
    assign rec       = pend_reg;
    assign rec_valid = pend_valid_reg;

    always_comb begin
        geom_ok = (row_count_reg != '0) && (32'(row_count_reg) <= 32'(MAX_ROWS)) &&
                  (column_count_reg != '0) && (32'(column_count_reg) <= 32'(MAX_COLS));
        total   = GEOM_W'(row_count_reg) * GEOM_W'(column_count_reg);
        first   = (idx_reg == '0);
        idx_inc = idx_reg + IDX_W'(1);
        fin     = CMP_W'(idx_inc) >= CMP_W'(total);

        crc_hdr = first ? crc_byte(crc_byte(CRC_INIT, cnt[15:8]), cnt[7:0]) : crc_reg;
        crc_dat = crc_byte(crc_byte(crc_hdr, smp[15:8]), smp[7:0]);
        crc_out = ~crc_dat;

        dat_bytes = {smp[7:0], smp[15:8]};
        hdr_bytes = {cnt[7:0], cnt[15:8], HDR_BYTE1, HDR_BYTE0};

        rec_new.fin = fin;
        rec_new.err = 1'b0;
        case ({first, fin})
            2'b11: begin
                rec_new.bytes = {crc_out, dat_bytes, hdr_bytes};
                rec_new.count = CNT_W'(10);
            end
            2'b10: begin
                rec_new.bytes = {32'd0, dat_bytes, hdr_bytes};
                rec_new.count = CNT_W'(6);
            end
            2'b01: begin
                rec_new.bytes = {32'd0, crc_out, dat_bytes};
                rec_new.count = CNT_W'(6);
            end
            default: begin
                rec_new.bytes = {64'd0, dat_bytes};
                rec_new.count = CNT_W'(2);
            end
        endcase

        crc_next = crc_dat;
        idx_next = idx_inc;
        if (!geom_ok) begin
            rec_new.bytes = '0;
            rec_new.count = CNT_W'(1);
            rec_new.fin   = 1'b0;
            rec_new.err   = 1'b1;
            crc_next      = CRC_INIT;
            idx_next      = '0;
        end else if (fin) begin
            crc_next = CRC_INIT;
            idx_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= ROW_COUNT_RST;
            column_count_reg <= COLUMN_COUNT_RST;
            crc_reg          <= CRC_INIT;
            idx_reg          <= '0;
            pend_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_ROW_COUNT:    row_count_reg    <= cfg_wdata;
                    REG_COLUMN_COUNT: column_count_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                crc_reg        <= crc_next;
                idx_reg        <= idx_next;
                pend_valid_reg <= 1'b1;
            end else if (rec_take) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg <= rec_new;
        end
    end

endmodule

[rtl/sfp_byte_ser.sv]
// ----------------------------------------------------------------------------
// sfp_byte_ser
// Byte serializer: loads one frame record and shifts it out one byte per
// transfer, flagging the closing CRC byte.
// ----------------------------------------------------------------------------
module sfp_byte_ser (
    input  logic              aclk,
    input  logic              aresetn,
    input  sfp_pkg::sfp_rec_t rec,
    input  logic              rec_valid,
    output logic              rec_take,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);
    import sfp_pkg::*;

    logic [BUF_W-1:0] buf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             fin_reg;
    logic             err_reg;
    logic             valid_reg;
    logic             xfer, final_byte;

    assign xfer       = valid_reg && m_tready;
    assign final_byte = (cnt_reg == CNT_W'(1));
    assign rec_take   = rec_valid && (!valid_reg || (xfer && final_byte));

    assign m_tvalid = valid_reg;
    assign m_tdata  = buf_reg[7:0];
    assign m_tlast  = fin_reg && final_byte;
    assign m_tuser  = err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (rec_take) begin
            valid_reg <= 1'b1;
        end else if (xfer && final_byte) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_take) begin
            buf_reg <= rec.bytes;
            cnt_reg <= rec.count;
            fin_reg <= rec.fin;
            err_reg <= rec.err;
        end else if (xfer) begin
            buf_reg <= buf_reg >> 8;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

endmodule

[rtl/sample_frame_packer_crc32_unit.sv]
// ----------------------------------------------------------------------------
// sample_frame_packer_crc32_unit
// Packs 16-bit matrix samples into byte frames: header FF 66, frame counter,
// samples MSB first, then CRC-32/ISO-HDLC LSB first.
// ----------------------------------------------------------------------------
// A sample is taken in one transfer and its bytes leave one per cycle on
// the byte-wide output while m_tready is high; a mid-frame sample yields 2
// bytes, the first sample of a frame 6, the last 6, a single-sample frame
// 10, and a sample taken under an invalid geometry 1 (one error transfer).
// The CRC over all bytes of a sample is updated at intake; one record waits
// behind the serializer so intake continues while output bytes are still
// pending.
module sample_frame_packer_crc32_unit #(
    parameter int MAX_ROWS = sfp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = sfp_pkg::DEF_MAX_COLS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sfp_pkg::CFG_ADR_W-1:0] cfg_addr,
    input  logic [sfp_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // sample, frame_counter
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // out_byte
    output logic                          m_tlast,
    output logic                          m_tuser    // error
);
    import sfp_pkg::*;

    sfp_rec_t rec;
    logic     rec_valid;
    logic     rec_take;

    sfp_framer #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_framer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .rec       (rec),
        .rec_valid (rec_valid),
        .rec_take  (rec_take)
    );

    sfp_byte_ser u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec       (rec),
        .rec_valid (rec_valid),
        .rec_take  (rec_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

[rtl/sfp_checker.sv]
// ----------------------------------------------------------------------------
// sfp_checker
// Port-level checks for the sample frame packer, bound to the top level.
// ----------------------------------------------------------------------------
module sfp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // error transfer carries a zero byte
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 8'd0))
        else $error("error transfer with nonzero byte");

    // error transfer never closes a frame
    a_err_nolast: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> !m_tlast)
        else $error("error transfer flagged last");

    // output idle right after reset
    a_rst_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // stalled transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
                                     $stable(m_tlast) && $stable(m_tuser)))
        else $error("output changed while stalled");

endmodule

bind sample_frame_packer_crc32_unit sfp_checker u_sfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
